@@ hw/rtl/palette_texel_morton_converter_unit_assert.svh @@
// Assertion macros shared by the converter RTL.
`ifndef PALETTE_TEXEL_MORTON_CONVERTER_UNIT_ASSERT_SVH
`define PALETTE_TEXEL_MORTON_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PTMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PTMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ptmc_pkg.sv @@
package ptmc_pkg;

    localparam int PALETTE_DEPTH   = 256;
    localparam int MAX_TEXTURE_DIM = 1024;
    localparam int PADDR_W         = 3;

    typedef enum logic [1:0] {
        FMT_I4    = 2'd0,
        FMT_I8    = 2'd1,
        FMT_D5551 = 2'd2,
        FMT_D4444 = 2'd3
    } fmt_t;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    localparam logic REG_PIXEL_FORMAT   = 1'b0;
    localparam logic REG_WIDTH_IN_TILES = 1'b1;

    localparam logic [5:0] TILE_COL_OFF [0:7] =
        '{6'd0, 6'd1, 6'd4, 6'd5, 6'd16, 6'd17, 6'd20, 6'd21};
    localparam logic [5:0] TILE_ROW_OFF [0:7] =
        '{6'd0, 6'd2, 6'd8, 6'd10, 6'd32, 6'd34, 6'd40, 6'd42};

    typedef struct packed {
        logic       we;
        logic [7:0] slot;
        logic [15:0] color;
    } pal_wr_t;

    typedef struct packed {
        fmt_t fmt;
        logic ld;
    } lane_ctrl_t;

    function automatic logic [15:0] remap5551(input logic [15:0] c);
        return {c[4:0], c[9:5], c[14:10], c[15]};
    endfunction

    function automatic logic [15:0] widen4444(input logic [15:0] c);
        return {c[3:0], c[3], c[7:4], c[7], c[11:8], c[11], |c[15:12]};
    endfunction

endpackage

@@ hw/rtl/ptmc_if.sv @@
interface ptmc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  palette_slot;
    logic [15:0] palette_color;
    logic [9:0]  texel_x;
    logic [9:0]  texel_y;
    logic [15:0] source_even;
    logic [15:0] source_odd;

    modport source (
        output valid, action, palette_slot, palette_color, texel_x, texel_y,
               source_even, source_odd,
        input  ready
    );
    modport sink (
        input  valid, action, palette_slot, palette_color, texel_x, texel_y,
               source_even, source_odd,
        output ready
    );
endinterface

interface ptmc_out_if;
    logic        valid;
    logic        ready;
    logic [18:0] pair_word_index;
    logic [15:0] texel_even_out;
    logic [15:0] texel_odd_out;

    modport source (
        output valid, pair_word_index, texel_even_out, texel_odd_out,
        input  ready
    );
    modport sink (
        input  valid, pair_word_index, texel_even_out, texel_odd_out,
        output ready
    );
endinterface

@@ hw/rtl/ptmc_ram.sv @@
module ptmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = ptmc_pkg::PALETTE_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/ptmc_lane.sv @@
module ptmc_lane #(
    parameter int PALETTE_DEPTH = ptmc_pkg::PALETTE_DEPTH
) (
    input  logic                  clk,
    input  ptmc_pkg::lane_ctrl_t  ctrl,
    input  ptmc_pkg::pal_wr_t     pal_wr,
    input  logic [15:0]           src,
    input  logic [3:0]            nib,
    output logic [15:0]           texel
);

    localparam int         AW        = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

    logic [7:0]  idx;
    logic        ok_next;
    logic        ok_reg;
    logic [15:0] src_reg;
    logic [15:0] pal_rd;

    assign idx     = (ctrl.fmt == ptmc_pkg::FMT_I4) ? {4'd0, nib} : src[7:0];
    assign ok_next = {1'b0, idx} < DEPTH_LIM;

    ptmc_ram #(
        .WIDTH (16),
        .DEPTH (PALETTE_DEPTH)
    ) u_pal (
        .clk   (clk),
        .we    (pal_wr.we),
        .waddr (pal_wr.slot[AW-1:0]),
        .wdata (pal_wr.color),
        .re    (ctrl.ld),
        .raddr (idx[AW-1:0]),
        .rdata (pal_rd)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.ld)
        begin
            src_reg <= src;
            ok_reg  <= ok_next;
        end
    end

    always_comb
    begin
        case (ctrl.fmt)
            ptmc_pkg::FMT_I4,
            ptmc_pkg::FMT_I8:    texel = ok_reg ? pal_rd : 16'd0;
            ptmc_pkg::FMT_D5551: texel = ptmc_pkg::remap5551(src_reg);
            default:             texel = ptmc_pkg::widen4444(src_reg);
        endcase
    end

endmodule

@@ hw/rtl/ptmc_merge.sv @@
module ptmc_merge (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s1_vld,
    input  logic [18:0] pwi,
    input  logic [15:0] texel_even,
    input  logic [15:0] texel_odd,
    output logic        adv,
    ptmc_out_if.source  result
);

    logic        vld_reg;
    logic [18:0] pwi_reg;
    logic [15:0] even_reg;
    logic [15:0] odd_reg;

    assign adv = !vld_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= s1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_vld)
        begin
            pwi_reg  <= pwi;
            even_reg <= texel_even;
            odd_reg  <= texel_odd;
        end
    end

    assign result.valid           = vld_reg;
    assign result.pair_word_index = pwi_reg;
    assign result.texel_even_out  = even_reg;
    assign result.texel_odd_out   = odd_reg;

endmodule

@@ hw/rtl/palette_texel_morton_converter_unit.sv @@
// Palette texel converter with 8x8 Morton tiling.
// item: valid/ready channel. A load item writes one remapped 5551 color into
//   the palette (no result); a convert item carries a texel pair at an even x.
// result: valid/ready channel with the destination pair-word index and the
//   two RGBA5551 texels (even x on texel_even_out).
// APB port: pixel_format at 0x0, width_in_tiles at 0x4; write only while idle.
// Throughput: one item per cycle while the output does not stall; both lanes
//   read their own palette copy in the same cycle. A result passes the palette
//   read register, then the output register.
// Loads are visible to a convert accepted in the very next cycle.
// Convert items with a coordinate out of range give no result.
// Reset: formats back to 4-bit indexed, width one tile, pipeline emptied;
//   palette contents are undefined until loaded.
// Stall: the output register holds; the middle stage still takes one more
//   convert item, then item.ready drops until the receiver takes the result.
`include "palette_texel_morton_converter_unit_assert.svh"

module palette_texel_morton_converter_unit #(
    parameter int PALETTE_DEPTH = ptmc_pkg::PALETTE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    ptmc_in_if.sink                      item,
    ptmc_out_if.source                   result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptmc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam logic [8:0]  DEPTH_LIM = 9'(PALETTE_DEPTH);
    localparam logic [10:0] DIM_LIM   = 11'(ptmc_pkg::MAX_TEXTURE_DIM);

    ptmc_pkg::fmt_t       fmt_reg;
    logic [7:0]           wit_reg;
    logic                 cfg_wr;
    logic                 ready;
    logic                 in_fire;
    logic                 cvt_fire;
    logic                 coord_ok;
    logic                 s1_vld_reg;
    logic                 s1_vld_next;
    logic                 out_adv;
    logic [14:0]          row_base;
    logic [5:0]           morton;
    logic [18:0]          pwi_next;
    logic [18:0]          pwi_reg;
    logic [15:0]          texel_even;
    logic [15:0]          texel_odd;
    ptmc_pkg::pal_wr_t    pal_wr;
    ptmc_pkg::lane_ctrl_t ctrl;

    // Configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= ptmc_pkg::FMT_I4;
            wit_reg <= 8'd1;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                ptmc_pkg::REG_PIXEL_FORMAT:   fmt_reg <= ptmc_pkg::fmt_t'(pwdata[1:0]);
                ptmc_pkg::REG_WIDTH_IN_TILES: wit_reg <= pwdata[7:0];
                default:                      wit_reg <= wit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ptmc_pkg::REG_PIXEL_FORMAT:   prdata = {30'd0, fmt_reg};
            ptmc_pkg::REG_WIDTH_IN_TILES: prdata = {24'd0, wit_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // Input stage
    assign ready      = !s1_vld_reg || out_adv;
    assign item.ready = ready;
    assign in_fire    = item.valid && ready;
    assign coord_ok   = ({1'b0, item.texel_x} < DIM_LIM) && ({1'b0, item.texel_y} < DIM_LIM);
    assign cvt_fire   = in_fire && (item.action == ptmc_pkg::ACT_CONVERT) && coord_ok;

    assign pal_wr.we    = in_fire && (item.action == ptmc_pkg::ACT_LOAD)
                          && ({1'b0, item.palette_slot} < DEPTH_LIM);
    assign pal_wr.slot  = item.palette_slot;
    assign pal_wr.color = ptmc_pkg::remap5551(item.palette_color);

    assign ctrl.fmt = fmt_reg;
    assign ctrl.ld  = ready;

    assign s1_vld_next = ready ? cvt_fire : s1_vld_reg;

    // Tiled address: tile row base, tile column, Morton offset within the tile
    assign row_base = {8'd0, item.texel_y[9:3]} * {7'd0, wit_reg};
    assign morton   = ptmc_pkg::TILE_ROW_OFF[item.texel_y[2:0]]
                    | ptmc_pkg::TILE_COL_OFF[item.texel_x[2:0]];
    assign pwi_next = 19'({row_base, 5'd0}) + 19'({item.texel_x[9:3], 5'd0})
                    + 19'(morton[5:1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            pwi_reg <= pwi_next;
        end
    end

    ptmc_lane #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_lane_even (
        .clk    (clk),
        .ctrl   (ctrl),
        .pal_wr (pal_wr),
        .src    (item.source_even),
        .nib    (item.source_even[3:0]),
        .texel  (texel_even)
    );

    ptmc_lane #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_lane_odd (
        .clk    (clk),
        .ctrl   (ctrl),
        .pal_wr (pal_wr),
        .src    (item.source_odd),
        .nib    (item.source_even[7:4]),
        .texel  (texel_odd)
    );

    ptmc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_vld     (s1_vld_reg),
        .pwi        (pwi_reg),
        .texel_even (texel_even),
        .texel_odd  (texel_odd),
        .adv        (out_adv),
        .result     (result)
    );

    `PTMC_ASSERT_NOW(a_load_no_convert, clk, rst_n, pal_wr.we, !s1_vld_next, "load with convert")
    `PTMC_ASSERT_NEXT(a_convert_enters, clk, rst_n, cvt_fire, s1_vld_reg, "convert transfer lost")
    `PTMC_ASSERT_NOW(a_full_blocks, clk, rst_n, !out_adv && s1_vld_reg, !item.ready, "full intake")

endmodule
